// File: rtl/core/cubic_bezier_spline_eval_defines.svh
// Assertion macros for the cubic Bezier spline evaluator.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef CUBIC_BEZIER_SPLINE_EVAL_DEFINES_SVH
`define CUBIC_BEZIER_SPLINE_EVAL_DEFINES_SVH

// Implication checked on the same clock edge
`define CBSE_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cbse assertion failed");

// Condition that holds at every clock edge
`define CBSE_ASSERT_ALWAYS(name, cond) \
   name: assert property (@(posedge clock) disable iff (reset) 1'b1 |-> (cond)) \
      else $error("cbse assertion failed");

`endif

// File: rtl/core/cbse_pkg.sv
// Shared types and constants for the cubic Bezier spline evaluator.
// No dependencies; used by the spline evaluator top level.
`timescale 1ns / 1ps

package cbse_pkg;

   // Default sizing of the spline table and fixed point format
   localparam int MAX_CURVES_DEF = 16;
   localparam int FRAC_BITS_DEF  = 16;

   // Coordinate width and internal value width (derivative terms need two more bits)
   localparam int COORD_W = 32;
   localparam int VAL_W   = COORD_W + 2;

   typedef enum logic [1:0] {
      CMD_LOAD       = 2'd0,
      CMD_EVAL_POS   = 2'd1,
      CMD_EVAL_DERIV = 2'd2,
      CMD_NOP        = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_SAT   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EXEC,
      S_MOD,
      S_READ,
      S_DIFF,
      S_MUL,
      S_ACC,
      S_SCALE,
      S_EMIT
   } state_type;

endpackage

// File: rtl/core/cbse_rem_unit.sv
// Iterative remainder unit: one quotient bit per cycle (restoring scheme).
// Depends on nothing; instantiated by the spline evaluator top level.
`timescale 1ns / 1ps

module cbse_rem_unit #(
   parameter int IW = 16,
   parameter int SW = 5
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [IW-1:0] dividend,
   input  logic [SW-1:0] divisor,
   output logic          done,
   output logic [SW-1:0] remainder
);

   localparam int CW = $clog2(IW + 1);

   logic          busy_ff;
   logic          done_ff;
   logic [CW-1:0] cnt_ff;
   logic [IW-1:0] dvd_ff;
   logic [SW-1:0] rem_ff;
   logic [SW-1:0] dsr_ff;
   logic [SW:0]   trial;
   logic          fits;
   logic [SW-1:0] rem_in;

   // Shift the next dividend bit in and subtract the divisor when it fits
   always_comb begin
      trial  = {rem_ff, dvd_ff[IW-1]};
      fits   = (trial >= {1'b0, dsr_ff});
      rem_in = fits ? SW'(trial - {1'b0, dsr_ff}) : trial[SW-1:0];
   end

   // Sequence the bit steps
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(IW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Hold operands and the partial remainder
   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dsr_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[IW-2:0], 1'b0};
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// File: rtl/core/cubic_bezier_spline_eval.sv
// Cubic Bezier spline evaluator. A load request appends one control point to the
// table; four points make a segment, up to MAX_CURVES segments. An evaluate request
// picks segment (integer part of time) mod (segment count) and returns the position
// or first derivative at the fraction, per coordinate, in signed fixed point with
// FRAC_BITS fraction bits, the derivative saturated to 32 bits. One request is in
// work at a time and req_tready is low meanwhile; a finished result may wait in the
// output register while the next request is taken. A load, a no-op or an evaluate
// on an empty spline passes through S_EXEC straight to S_EMIT. An evaluate runs
// the bit-serial remainder for the segment, then for each coordinate reads its
// four points through one registered memory port and interpolates with one
// shared multiplier, each interpolation step taking S_MUL and then S_ACC.
// Depends on cbse_pkg, cbse_rem_unit and cubic_bezier_spline_eval_defines.svh.
`timescale 1ns / 1ps

`include "cubic_bezier_spline_eval_defines.svh"

module cubic_bezier_spline_eval #(
   parameter int MAX_CURVES = cbse_pkg::MAX_CURVES_DEF,
   parameter int FRAC_BITS  = cbse_pkg::FRAC_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // point_x, point_y, point_z, time_req
   input  logic [1:0]   req_tuser,  // command
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,  // out_x, out_y, out_z, curve_count, zero pad
   output logic [1:0]   rsp_tuser   // status
);

   localparam int DEPTH = 4 * MAX_CURVES;
   localparam int AW    = $clog2(DEPTH);
   localparam int SW    = $clog2(MAX_CURVES + 1);
   localparam int IW    = 32 - FRAC_BITS;
   localparam int CW    = cbse_pkg::COORD_W;
   localparam int VW    = cbse_pkg::VAL_W;
   localparam int DW    = VW + 1;
   localparam int PW    = DW + FRAC_BITS + 1;
   localparam int SCW   = VW + 2;

   localparam logic [SW-1:0]        MAX_CNT = SW'(MAX_CURVES);
   localparam logic signed [PW-1:0] HALF    = {{(PW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
   localparam logic signed [SCW-1:0] S_MAX  = SCW'(signed'(32'h7FFF_FFFF));
   localparam logic signed [SCW-1:0] S_MIN  = SCW'(signed'(32'h8000_0000));

   // Control state
   cbse_pkg::state_type state_ff, state_in;
   logic [1:0]    pend_ff;
   logic [SW-1:0] seg_cnt_ff;
   logic [1:0]    coord_ff;
   logic [1:0]    lvl_ff;
   logic [1:0]    pos_ff;
   logic [2:0]    rd_cnt_ff;
   logic          rsp_tvalid_ff;

   // Request and working registers
   cbse_pkg::cmd_type    cmd_ff;
   cbse_pkg::status_type status_ff;
   logic [CW-1:0]        px_ff, py_ff, pz_ff;
   logic [31:0]          time_ff;
   logic [SW-1:0]        base_ff;
   logic signed [VW-1:0] w_ff [0:3];
   logic signed [PW-1:0] prod_ff;
   logic [CW-1:0]        res_ff [0:2];
   logic                 sat_ff;
   logic [103:0]         rsp_data_ff;
   logic [1:0]           rsp_user_ff;

   // Point table
   logic [CW-1:0] mem_x [0:DEPTH-1];
   logic [CW-1:0] mem_y [0:DEPTH-1];
   logic [CW-1:0] mem_z [0:DEPTH-1];
   logic [CW-1:0] rd_x_ff, rd_y_ff, rd_z_ff;
   logic [AW-1:0] wr_addr, rd_addr;

   // FSM outputs and datapath nets
   logic                  mem_we, mod_start, out_load;
   logic                  mod_done;
   logic [SW-1:0]         mod_rem;
   logic                  is_eval, is_deriv, last_pair;
   logic [1:0]            pos_nx, rd_idx;
   logic [CW-1:0]         rd_sel;
   logic signed [DW-1:0]  mul_a;
   logic signed [FRAC_BITS:0] mul_b;
   logic signed [PW-1:0]  mul_p;
   logic signed [PW-1:0]  rnd_v;
   logic signed [VW-1:0]  step_v;
   logic signed [SCW-1:0] tri_v;
   logic                  over, under;
   logic [CW-1:0]         sat_v;

   assign is_eval   = (cmd_ff == cbse_pkg::CMD_EVAL_POS) || (cmd_ff == cbse_pkg::CMD_EVAL_DERIV);
   assign is_deriv  = (cmd_ff == cbse_pkg::CMD_EVAL_DERIV);
   assign last_pair = (pos_ff == (2'd2 - lvl_ff));
   assign pos_nx    = pos_ff + 2'd1;
   assign rd_idx    = 2'(rd_cnt_ff - 3'd1);
   assign wr_addr   = AW'({seg_cnt_ff, pend_ff});
   assign rd_addr   = AW'({base_ff, rd_cnt_ff[1:0]});

   // Segment index: integer part of time modulo the segment count
   cbse_rem_unit #(
      .IW(IW),
      .SW(SW)
   ) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (time_ff[31:FRAC_BITS]),
      .divisor   (seg_cnt_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cbse_pkg::S_IDLE:  if (req_tvalid) state_in = cbse_pkg::S_EXEC;
         cbse_pkg::S_EXEC: begin
            if (is_eval && (seg_cnt_ff != '0)) state_in = cbse_pkg::S_MOD;
            else state_in = cbse_pkg::S_EMIT;
         end
         cbse_pkg::S_MOD:   if (mod_done) state_in = cbse_pkg::S_READ;
         cbse_pkg::S_READ: begin
            if (rd_cnt_ff == 3'd4) state_in = is_deriv ? cbse_pkg::S_DIFF : cbse_pkg::S_MUL;
         end
         cbse_pkg::S_DIFF:  state_in = cbse_pkg::S_MUL;
         cbse_pkg::S_MUL:   state_in = cbse_pkg::S_ACC;
         cbse_pkg::S_ACC: begin
            if (last_pair && (lvl_ff == 2'd2)) state_in = cbse_pkg::S_SCALE;
            else state_in = cbse_pkg::S_MUL;
         end
         cbse_pkg::S_SCALE: begin
            state_in = (coord_ff == 2'd2) ? cbse_pkg::S_EMIT : cbse_pkg::S_READ;
         end
         cbse_pkg::S_EMIT:  if (!rsp_tvalid_ff || rsp_tready) state_in = cbse_pkg::S_IDLE;
         default:           state_in = cbse_pkg::S_IDLE;
      endcase
   end

   // FSM outputs
   always_comb begin
      req_tready = (state_ff == cbse_pkg::S_IDLE);
      mem_we     = (state_ff == cbse_pkg::S_EXEC) && (cmd_ff == cbse_pkg::CMD_LOAD) &&
                   (seg_cnt_ff < MAX_CNT);
      mod_start  = (state_ff == cbse_pkg::S_EXEC) && is_eval && (seg_cnt_ff != '0);
      out_load   = (state_ff == cbse_pkg::S_EMIT) && (!rsp_tvalid_ff || rsp_tready);
   end

   // Shared multiply, rounding and scaling
   always_comb begin
      unique case (coord_ff)
         2'd0:    rd_sel = rd_x_ff;
         2'd1:    rd_sel = rd_y_ff;
         default: rd_sel = rd_z_ff;
      endcase
      mul_a  = {w_ff[pos_nx][VW-1], w_ff[pos_nx]} - {w_ff[pos_ff][VW-1], w_ff[pos_ff]};
      mul_b  = signed'({1'b0, time_ff[FRAC_BITS-1:0]});
      mul_p  = mul_a * mul_b;
      rnd_v  = (prod_ff + HALF) >>> FRAC_BITS;
      step_v = rnd_v[VW-1:0];
      tri_v  = {{2{w_ff[0][VW-1]}}, w_ff[0]};
      if (is_deriv) tri_v = tri_v + {w_ff[0][VW-1], w_ff[0], 1'b0};
      over   = (tri_v > S_MAX);
      under  = (tri_v < S_MIN);
      if (over) sat_v = 32'h7FFF_FFFF;
      else if (under) sat_v = 32'h8000_0000;
      else sat_v = tri_v[CW-1:0];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= cbse_pkg::S_IDLE;
         pend_ff       <= '0;
         seg_cnt_ff    <= '0;
         coord_ff      <= '0;
         lvl_ff        <= '0;
         pos_ff        <= '0;
         rd_cnt_ff     <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         // advance the fill position on a load
         if (mem_we) begin
            pend_ff <= pend_ff + 2'd1;
            if (pend_ff == 2'd3) seg_cnt_ff <= seg_cnt_ff + SW'(1);
         end
         if (mod_start) begin
            coord_ff  <= '0;
            rd_cnt_ff <= '0;
         end
         case (state_ff)
            cbse_pkg::S_READ: begin
               if (rd_cnt_ff == 3'd4) begin
                  rd_cnt_ff <= '0;
                  lvl_ff    <= is_deriv ? 2'd1 : 2'd0;
                  pos_ff    <= '0;
               end else begin
                  rd_cnt_ff <= rd_cnt_ff + 3'd1;
               end
            end
            cbse_pkg::S_ACC: begin
               if (last_pair) begin
                  pos_ff <= '0;
                  lvl_ff <= lvl_ff + 2'd1;
               end else begin
                  pos_ff <= pos_nx;
               end
            end
            cbse_pkg::S_SCALE: coord_ff <= coord_ff + 2'd1;
            default: ;
         endcase
         // hold the result until taken
         if (out_load) rsp_tvalid_ff <= 1'b1;
         else if (rsp_tready) rsp_tvalid_ff <= 1'b0;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         cmd_ff  <= cbse_pkg::cmd_type'(req_tuser);
         px_ff   <= req_tdata[31:0];
         py_ff   <= req_tdata[63:32];
         pz_ff   <= req_tdata[95:64];
         time_ff <= req_tdata[127:96];
      end
      if (mod_done) base_ff <= mod_rem;
      case (state_ff)
         cbse_pkg::S_EXEC: begin
            res_ff[0] <= '0;
            res_ff[1] <= '0;
            res_ff[2] <= '0;
            sat_ff    <= 1'b0;
            if ((cmd_ff == cbse_pkg::CMD_LOAD) && (seg_cnt_ff >= MAX_CNT))
               status_ff <= cbse_pkg::STATUS_FULL;
            else if (is_eval && (seg_cnt_ff == '0))
               status_ff <= cbse_pkg::STATUS_EMPTY;
            else
               status_ff <= cbse_pkg::STATUS_OK;
         end
         cbse_pkg::S_READ: begin
            if (rd_cnt_ff != 3'd0) w_ff[rd_idx] <= {{(VW-CW){rd_sel[CW-1]}}, rd_sel};
         end
         cbse_pkg::S_DIFF: begin
            for (int i = 0; i < 3; i++) w_ff[i] <= w_ff[i+1] - w_ff[i];
         end
         cbse_pkg::S_MUL:   prod_ff <= mul_p;
         cbse_pkg::S_ACC:   w_ff[pos_ff] <= w_ff[pos_ff] + step_v;
         cbse_pkg::S_SCALE: begin
            res_ff[coord_ff] <= sat_v;
            if (over || under) sat_ff <= 1'b1;
         end
         default: ;
      endcase
      // load the output register
      if (out_load) begin
         rsp_data_ff <= {3'b000, 5'(seg_cnt_ff), res_ff[2], res_ff[1], res_ff[0]};
         rsp_user_ff <= sat_ff ? cbse_pkg::STATUS_SAT : status_ff;
      end
   end

   // Point table: one write port, one registered read port per coordinate
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_x[wr_addr] <= px_ff;
         mem_y[wr_addr] <= py_ff;
         mem_z[wr_addr] <= pz_ff;
      end
      rd_x_ff <= mem_x[rd_addr];
      rd_y_ff <= mem_y[rd_addr];
      rd_z_ff <= mem_z[rd_addr];
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `CBSE_ASSERT_ALWAYS(a_open_seg_room, (pend_ff == 2'd0) || (seg_cnt_ff < MAX_CNT))
   `CBSE_ASSERT_IMPL(a_sat_only_deriv, out_load && sat_ff, cmd_ff == cbse_pkg::CMD_EVAL_DERIV)
   `CBSE_ASSERT_IMPL(a_rem_done_in_wait, mod_done, state_ff == cbse_pkg::S_MOD)
   `CBSE_ASSERT_IMPL(a_seg_in_range, state_ff == cbse_pkg::S_READ, base_ff < seg_cnt_ff)

endmodule
